// File: hdl/dlp_pkg.sv
// Shared types and constants of the DAG longest-path unit.
package dlp_pkg;

    localparam int MAX_NODES = 256;
    localparam int MAX_EDGES = 1024;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int NCNT_W    = $clog2(MAX_NODES + 1);
    localparam int EIDX_W    = $clog2(MAX_EDGES);
    localparam int ECNT_W    = $clog2(MAX_EDGES + 1);
    localparam int DEG_W     = ECNT_W;
    localparam int LEN_W     = 8;
    localparam int ADDR_W    = 3;

    localparam logic ACT_EDGE   = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    localparam logic REG_NODE_COUNT = 1'b0;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    typedef struct packed {
        logic             action;
        logic [NODE_W-1:0] edge_source;
        logic [NODE_W-1:0] edge_target;
    } item_t;

    typedef struct packed {
        logic [LEN_W-1:0]  longest_path;
        logic [NCNT_W-1:0] nodes_ordered;
        logic              edges_dropped;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_CNT_RD,
        S_CNT_IDX,
        S_CNT_WR,
        S_SEED_RD,
        S_SEED_CHK,
        S_Q_RD,
        S_Q_CUR,
        S_Q_LEN,
        S_E_RD,
        S_E_IDX,
        S_E_WR,
        S_MAX_RD,
        S_MAX_CMP,
        S_OUT
    } state_t;

endpackage

// File: hdl/dag_longest_path_unit.sv
// Top level of the DAG longest-path unit: edge store, sequencer and result register.
//
//   Channel   Signals                             Moves
//   -------   ---------------------------------   ------------------------------
//   item      item_valid, item_stall, item        one edge or a finish beat
//   result    result_valid, result_stall, result  one result beat per finish
//   config    psel, penable, pwrite, paddr, ...   node_count at address 0
//
// An edge beat is taken whenever the sequencer is idle, even while an earlier
// result still waits in the output register. A finish beat runs a sequencer
// over its memories: it clears the node tables, counts in-degrees over the
// stored edges, seeds the queue, scans the edge list for each ordered node and
// finally finds the maximum path length over the nodes in use.
// The scan of the whole edge list for each ordered node dominates. Reset clears
// the control state only; memories are written before they are read. A stalled
// result simply holds the sequencer in its final state until the beat is taken.
module dag_longest_path_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  dlp_pkg::item_t                item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output dlp_pkg::result_t              result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dlp_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // Configuration.
    logic [dlp_pkg::NCNT_W-1:0] node_count_reg;
    logic [dlp_pkg::NCNT_W-1:0] n_eff;
    logic                       cfg_write;

    // Sequencer state and counters.
    dlp_pkg::state_t            state_reg, state_next;
    logic [dlp_pkg::ECNT_W-1:0] edges_loaded_reg, edges_loaded_next;
    logic                       drop_reg, drop_next;
    logic [dlp_pkg::NCNT_W-1:0] v_reg, v_next;
    logic [dlp_pkg::ECNT_W-1:0] e_reg, e_next;
    logic [dlp_pkg::NCNT_W-1:0] head_reg, head_next;
    logic [dlp_pkg::NCNT_W-1:0] tail_reg, tail_next;
    logic [dlp_pkg::NODE_W-1:0] cur_reg, cur_next;
    logic [dlp_pkg::LEN_W-1:0]  cand_reg, cand_next;
    logic [dlp_pkg::LEN_W-1:0]  best_reg, best_next;
    logic                       out_valid_reg, out_valid_next;
    dlp_pkg::result_t           out_reg, out_next;

    // Memories.
    logic [dlp_pkg::NODE_W-1:0] src_mem [dlp_pkg::MAX_EDGES];
    logic [dlp_pkg::NODE_W-1:0] tgt_mem [dlp_pkg::MAX_EDGES];
    logic [dlp_pkg::DEG_W-1:0]  deg_mem [dlp_pkg::MAX_NODES];
    logic [dlp_pkg::LEN_W-1:0]  len_mem [dlp_pkg::MAX_NODES];
    logic [dlp_pkg::NODE_W-1:0] q_mem   [dlp_pkg::MAX_NODES];

    logic [dlp_pkg::NODE_W-1:0] src_rd, tgt_rd, q_rd;
    logic [dlp_pkg::DEG_W-1:0]  deg_rd, deg_wdata;
    logic [dlp_pkg::LEN_W-1:0]  len_rd, len_wdata;
    logic                       e_we, deg_we, len_we, q_we;
    logic [dlp_pkg::NODE_W-1:0] n_raddr, n_waddr, q_wdata;
    logic                       item_take;

    assign item_stall   = (state_reg != dlp_pkg::S_IDLE);
    assign item_take    = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Node counts above the store size behave as the store size.
    assign n_eff = (node_count_reg > dlp_pkg::NCNT_W'(dlp_pkg::MAX_NODES))
                 ? dlp_pkg::NCNT_W'(dlp_pkg::MAX_NODES) : node_count_reg;

    // Configuration port: always ready, one register at address zero.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            dlp_pkg::REG_NODE_COUNT: prdata = {{(32 - dlp_pkg::NCNT_W){1'b0}}, node_count_reg};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= '0;
        end
        else if (cfg_write && (paddr[2] == dlp_pkg::REG_NODE_COUNT))
        begin
            node_count_reg <= pwdata[dlp_pkg::NCNT_W-1:0];
        end
    end

    // Edge store: written on an accepted edge beat, read at the edge counter.
    assign e_we = item_take && (item.action == dlp_pkg::ACT_EDGE)
               && ({1'b0, item.edge_source} < n_eff) && ({1'b0, item.edge_target} < n_eff)
               && (edges_loaded_reg < dlp_pkg::ECNT_W'(dlp_pkg::MAX_EDGES));

    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            src_mem[edges_loaded_reg[dlp_pkg::EIDX_W-1:0]] <= item.edge_source;
            tgt_mem[edges_loaded_reg[dlp_pkg::EIDX_W-1:0]] <= item.edge_target;
        end
        src_rd <= src_mem[e_reg[dlp_pkg::EIDX_W-1:0]];
        tgt_rd <= tgt_mem[e_reg[dlp_pkg::EIDX_W-1:0]];
    end

    // Per-node in-degree and path length share one read and one write address.
    always_ff @(posedge clk)
    begin
        if (deg_we)
        begin
            deg_mem[n_waddr] <= deg_wdata;
        end
        if (len_we)
        begin
            len_mem[n_waddr] <= len_wdata;
        end
        deg_rd <= deg_mem[n_raddr];
        len_rd <= len_mem[n_raddr];
    end

    // Ready queue of nodes whose in-degree has reached zero.
    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[tail_reg[dlp_pkg::NODE_W-1:0]] <= q_wdata;
        end
        q_rd <= q_mem[head_reg[dlp_pkg::NODE_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= dlp_pkg::S_IDLE;
            edges_loaded_reg <= '0;
            drop_reg         <= 1'b0;
            v_reg            <= '0;
            e_reg            <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            cur_reg          <= '0;
            cand_reg         <= '0;
            best_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            edges_loaded_reg <= edges_loaded_next;
            drop_reg         <= drop_next;
            v_reg            <= v_next;
            e_reg            <= e_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            cur_reg          <= cur_next;
            cand_reg         <= cand_next;
            best_reg         <= best_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // Sequencer: every step is at most one memory read or one read-modify-write.
    always_comb
    begin
        state_next        = state_reg;
        edges_loaded_next = edges_loaded_reg;
        drop_next         = drop_reg;
        v_next            = v_reg;
        e_next            = e_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        cur_next          = cur_reg;
        cand_next         = cand_reg;
        best_next         = best_reg;
        out_valid_next    = out_valid_reg && result_stall;
        out_next          = out_reg;
        deg_we            = 1'b0;
        len_we            = 1'b0;
        q_we              = 1'b0;
        n_raddr           = tgt_rd;
        n_waddr           = tgt_rd;
        deg_wdata         = deg_rd + dlp_pkg::DEG_W'(1);
        len_wdata         = '0;
        q_wdata           = tgt_rd;

        unique case (state_reg)
            dlp_pkg::S_IDLE:
            begin
                if (item_take)
                begin
                    if (item.action == dlp_pkg::ACT_FINISH)
                    begin
                        v_next     = '0;
                        tail_next  = '0;
                        head_next  = '0;
                        best_next  = '0;
                        state_next = dlp_pkg::S_CLR;
                    end
                    else if (e_we)
                    begin
                        edges_loaded_next = edges_loaded_reg + dlp_pkg::ECNT_W'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                end
            end
            dlp_pkg::S_CLR:
            begin
                if (v_reg < n_eff)
                begin
                    n_waddr   = v_reg[dlp_pkg::NODE_W-1:0];
                    deg_we    = 1'b1;
                    len_we    = 1'b1;
                    deg_wdata = '0;
                    v_next    = v_reg + dlp_pkg::NCNT_W'(1);
                end
                else
                begin
                    e_next     = '0;
                    state_next = dlp_pkg::S_CNT_RD;
                end
            end
            dlp_pkg::S_CNT_RD:
            begin
                if (e_reg < edges_loaded_reg)
                begin
                    state_next = dlp_pkg::S_CNT_IDX;
                end
                else
                begin
                    v_next     = '0;
                    state_next = dlp_pkg::S_SEED_RD;
                end
            end
            dlp_pkg::S_CNT_IDX:
            begin
                // Edges made stale by a smaller node count are skipped as dropped.
                if (({1'b0, src_rd} < n_eff) && ({1'b0, tgt_rd} < n_eff))
                begin
                    state_next = dlp_pkg::S_CNT_WR;
                end
                else
                begin
                    drop_next  = 1'b1;
                    e_next     = e_reg + dlp_pkg::ECNT_W'(1);
                    state_next = dlp_pkg::S_CNT_RD;
                end
            end
            dlp_pkg::S_CNT_WR:
            begin
                deg_we     = 1'b1;
                e_next     = e_reg + dlp_pkg::ECNT_W'(1);
                state_next = dlp_pkg::S_CNT_RD;
            end
            dlp_pkg::S_SEED_RD:
            begin
                n_raddr = v_reg[dlp_pkg::NODE_W-1:0];
                if (v_reg < n_eff)
                begin
                    state_next = dlp_pkg::S_SEED_CHK;
                end
                else
                begin
                    state_next = dlp_pkg::S_Q_RD;
                end
            end
            dlp_pkg::S_SEED_CHK:
            begin
                if (deg_rd == '0)
                begin
                    q_we      = 1'b1;
                    q_wdata   = v_reg[dlp_pkg::NODE_W-1:0];
                    tail_next = tail_reg + dlp_pkg::NCNT_W'(1);
                end
                v_next     = v_reg + dlp_pkg::NCNT_W'(1);
                state_next = dlp_pkg::S_SEED_RD;
            end
            dlp_pkg::S_Q_RD:
            begin
                if (head_reg < tail_reg)
                begin
                    state_next = dlp_pkg::S_Q_CUR;
                end
                else
                begin
                    v_next     = '0;
                    state_next = dlp_pkg::S_MAX_RD;
                end
            end
            dlp_pkg::S_Q_CUR:
            begin
                n_raddr    = q_rd;
                cur_next   = q_rd;
                head_next  = head_reg + dlp_pkg::NCNT_W'(1);
                state_next = dlp_pkg::S_Q_LEN;
            end
            dlp_pkg::S_Q_LEN:
            begin
                cand_next  = (len_rd == dlp_pkg::LEN_MAX) ? len_rd
                           : len_rd + dlp_pkg::LEN_W'(1);
                e_next     = '0;
                state_next = dlp_pkg::S_E_RD;
            end
            dlp_pkg::S_E_RD:
            begin
                if (e_reg < edges_loaded_reg)
                begin
                    state_next = dlp_pkg::S_E_IDX;
                end
                else
                begin
                    state_next = dlp_pkg::S_Q_RD;
                end
            end
            dlp_pkg::S_E_IDX:
            begin
                if ((src_rd == cur_reg) && ({1'b0, tgt_rd} < n_eff))
                begin
                    state_next = dlp_pkg::S_E_WR;
                end
                else
                begin
                    e_next     = e_reg + dlp_pkg::ECNT_W'(1);
                    state_next = dlp_pkg::S_E_RD;
                end
            end
            dlp_pkg::S_E_WR:
            begin
                len_we    = 1'b1;
                len_wdata = (len_rd < cand_reg) ? cand_reg : len_rd;
                deg_we    = 1'b1;
                deg_wdata = (deg_rd != '0) ? deg_rd - dlp_pkg::DEG_W'(1) : '0;
                if ((deg_rd == dlp_pkg::DEG_W'(1))
                    && (tail_reg < dlp_pkg::NCNT_W'(dlp_pkg::MAX_NODES)))
                begin
                    q_we      = 1'b1;
                    tail_next = tail_reg + dlp_pkg::NCNT_W'(1);
                end
                e_next     = e_reg + dlp_pkg::ECNT_W'(1);
                state_next = dlp_pkg::S_E_RD;
            end
            dlp_pkg::S_MAX_RD:
            begin
                n_raddr = v_reg[dlp_pkg::NODE_W-1:0];
                if (v_reg < n_eff)
                begin
                    state_next = dlp_pkg::S_MAX_CMP;
                end
                else
                begin
                    state_next = dlp_pkg::S_OUT;
                end
            end
            dlp_pkg::S_MAX_CMP:
            begin
                if (len_rd > best_reg)
                begin
                    best_next = len_rd;
                end
                v_next     = v_reg + dlp_pkg::NCNT_W'(1);
                state_next = dlp_pkg::S_MAX_RD;
            end
            dlp_pkg::S_OUT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next           = 1'b1;
                    out_next.longest_path    = best_reg;
                    out_next.nodes_ordered   = tail_reg;
                    out_next.edges_dropped   = drop_reg;
                    edges_loaded_next        = '0;
                    drop_next                = 1'b0;
                    state_next               = dlp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dlp_pkg::S_IDLE;
            end
        endcase
    end

endmodule
